>>> hw/rtl/tcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants, field widths and codes of the text console engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

    // Screen geometry.
    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = ROWS * COLS;

    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    // Field widths of the request and response words.
    localparam int FUNC_W    = 1;
    localparam int CHAR_W    = 8;
    localparam int RD_ROW_W  = 5;
    localparam int RD_COL_W  = 7;
    localparam int CELL_W    = 16;
    localparam int CUR_COL_W = 7;
    localparam int CUR_ROW_W = 5;
    localparam int COLOR_W   = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COLOR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 1'd1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    // Request function codes.
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 1'b1;

    // Character codes.
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

    localparam logic [CELL_W-1:0] RESET_CELL = {BG_RESET, FG_RESET, SPACE_CODE};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } tcc_state_t;

endpackage

>>> hw/rtl/tcc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_req_if / tcc_rsp_if
// Valid/ready channels carrying request and response words of the console.
// ----------------------------------------------------------------------------
interface tcc_req_if
    import tcc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [CHAR_W-1:0]   char_code;
    logic [RD_ROW_W-1:0] read_row;
    logic [RD_COL_W-1:0] read_col;

    modport source (output valid, func, char_code, read_row, read_col, input ready);
    modport sink   (input valid, func, char_code, read_row, read_col, output ready);
endinterface

interface tcc_rsp_if
    import tcc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_value;
    logic [CUR_COL_W-1:0] cursor_col;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic                 scrolled;

    modport source (output valid, cell_value, cursor_col, cursor_row, scrolled, input ready);
    modport sink   (input valid, cell_value, cursor_col, cursor_row, scrolled, output ready);
endinterface

>>> hw/rtl/text_console_cursor_scroll.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console engine: ring-organized screen store, cursor and scrolling.
// ----------------------------------------------------------------------------
// Write word: response registered at the accepting edge, next word taken the next cycle
// unless the response stalls. Read word: registered store read, then response register;
// none taken meanwhile. A scroll stalls words while the single write port clears a row.
// Reset: cursor, row offset and colors go to defaults, then the store write port sweeps
// all ROWS*COLS (2000) cells to spaces; no word is accepted during that sweep, while
// configuration writes are taken.
module text_console_cursor_scroll
    import tcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tcc_req_if.sink               req,
    tcc_rsp_if.source             rsp
);

    localparam int SUM_W = ROW_W + 1;

    tcc_state_t state_reg, state_next;

    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]   row_offset_reg, row_offset_next;
    logic [COLOR_W-1:0] fg_reg, bg_reg;

    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]  clr_end_reg, clr_end_next;
    logic [CELL_W-1:0]  clr_cell_reg, clr_cell_next;

    logic               out_valid_reg;
    logic [CELL_W-1:0]  out_cell_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic               out_scr_reg;
    logic               rd_ok_reg;

    logic [CELL_W-1:0]  screen_mem [CELLS];
    logic [CELL_W-1:0]  rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;

    logic               acc;
    logic               acc_read;
    logic               acc_write;
    logic               is_newline;
    logic               line_end;
    logic               scroll;
    logic               rd_ok;
    logic               load_wr;
    logic               load_rd;

    function automatic logic [ROW_W-1:0] store_row(input logic [ROW_W-1:0] r,
                                                   input logic [ROW_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = {1'b0, r} + {1'b0, off};
        if (s >= SUM_W'(ROWS))
            s = s - SUM_W'(ROWS);
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] srow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(srow) * ADDR_W'(COLS)) + ADDR_W'(col);
    endfunction

    assign acc        = req.valid && req.ready;
    assign acc_read   = acc && (req.func == FUNC_READ);
    assign acc_write  = acc && (req.func == FUNC_WRITE);
    assign is_newline = (req.char_code == NEWLINE_CODE);
    assign line_end   = is_newline || (cur_col_reg == COL_W'(COLS - 1));
    assign scroll     = acc_write && line_end && (cur_row_reg == ROW_W'(ROWS - 1));
    assign rd_ok      = (req.read_row < RD_ROW_W'(ROWS)) && (req.read_col < RD_COL_W'(COLS));
    assign load_wr    = acc_write;
    assign load_rd    = (state_reg == ST_READ);
    assign mem_raddr  = rd_ok ? cell_addr(store_row(ROW_W'(req.read_row), row_offset_reg),
                                          COL_W'(req.read_col))
                              : '0;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == clr_end_reg)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (acc_read)
                    state_next = ST_READ;
                else if (scroll)
                    state_next = ST_CLEAR;
            end
            ST_READ:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshake and store write port.
    always_comb
    begin
        req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = clr_cell_reg;
        unique case (state_reg)
            ST_CLEAR:
                mem_we = 1'b1;
            ST_IDLE:
            begin
                if (acc_write && !is_newline)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cell_addr(store_row(cur_row_reg, row_offset_reg), cur_col_reg);
                    mem_wdata = {bg_reg, fg_reg, req.char_code};
                end
            end
            ST_READ:
                mem_we = 1'b0;
            default:
                mem_we = 1'b0;
        endcase
    end

    // Cursor, offset and clearing sweep.
    always_comb
    begin
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        row_offset_next = row_offset_reg;
        clr_addr_next   = clr_addr_reg;
        clr_end_next    = clr_end_reg;
        clr_cell_next   = clr_cell_reg;
        if (state_reg == ST_CLEAR)
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
        if (acc_write)
        begin
            if (line_end)
            begin
                cur_col_next = '0;
                if (!scroll)
                    cur_row_next = cur_row_reg + ROW_W'(1);
            end
            else
            begin
                cur_col_next = cur_col_reg + COL_W'(1);
            end
        end
        // The row that leaves the top becomes the new bottom row.
        if (scroll)
        begin
            row_offset_next = (row_offset_reg == ROW_W'(ROWS - 1)) ? '0
                                                                   : row_offset_reg + ROW_W'(1);
            clr_addr_next   = cell_addr(row_offset_reg, '0);
            clr_end_next    = cell_addr(row_offset_reg, COL_W'(COLS - 1));
            clr_cell_next   = {bg_reg, fg_reg, SPACE_CODE};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            row_offset_reg <= '0;
            fg_reg         <= FG_RESET;
            bg_reg         <= BG_RESET;
            clr_addr_reg   <= '0;
            clr_end_reg    <= ADDR_W'(CELLS - 1);
            clr_cell_reg   <= RESET_CELL;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            row_offset_reg <= row_offset_next;
            clr_addr_reg   <= clr_addr_next;
            clr_end_reg    <= clr_end_next;
            clr_cell_reg   <= clr_cell_next;
            if (cfg_we && cfg_index == CFG_FG_COLOR)
                fg_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_BG_COLOR)
                bg_reg <= cfg_data;
            if (load_wr || load_rd)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Response word payload.
    always_ff @(posedge clk)
    begin
        if (acc_read)
            rd_ok_reg <= rd_ok;
        if (load_wr)
        begin
            out_cell_reg <= '0;
            out_col_reg  <= cur_col_next;
            out_row_reg  <= cur_row_next;
            out_scr_reg  <= scroll;
        end
        else if (load_rd)
        begin
            out_cell_reg <= rd_ok_reg ? rd_data_reg : '0;
            out_col_reg  <= cur_col_reg;
            out_row_reg  <= cur_row_reg;
            out_scr_reg  <= 1'b0;
        end
    end

    // Screen store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            screen_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= screen_mem[mem_raddr];
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.cell_value = out_cell_reg;
    assign rsp.cursor_col = CUR_COL_W'(out_col_reg);
    assign rsp.cursor_row = CUR_ROW_W'(out_row_reg);
    assign rsp.scrolled   = out_scr_reg;

    a_scroll_clears: assert property (@(posedge clk) disable iff (!rst_n)
        scroll |=> (state_reg == ST_CLEAR) && !req.ready)
        else $error("scrolling write did not start the row clear");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_col_reg < COL_W'(COLS)) && (cur_row_reg < ROW_W'(ROWS)))
        else $error("cursor left the screen");

    a_read_response: assert property (@(posedge clk) disable iff (!rst_n)
        acc_read |=> ##1 rsp.valid)
        else $error("read word produced no response");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.scrolled) |->
        (out_col_reg == '0) && (out_row_reg == ROW_W'(ROWS - 1)))
        else $error("scroll response with cursor off the bottom line start");

endmodule

>>> tb/tb_text_console_cursor_scroll.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll
// Self-checking bench for the text console engine. A short table of words
// covers the reset screen, reads out of range, writes, newlines and read-back.
// Random traffic follows: lines of text, some long enough to wrap, and reads
// of cells, some out of range. It runs under several color settings, with
// random gaps on both channels in all but the last. A shadow copy of screen,
// cursor and scroll offset predicts untyped responses, checked field by field.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll
    import tcc_pkg::*;
;

    localparam int ITEMS_PER_PHASE = 258;
    localparam int DIRECTED_N      = 18;
    // Cycles for a scroll to finish clearing its row after the response.
    localparam int SETTLE_CYCLES   = COLS + 20;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [CHAR_W-1:0]   char_code;
        logic [RD_ROW_W-1:0] read_row;
        logic [RD_COL_W-1:0] read_col;
    } console_req_t;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_value;
        logic [CUR_COL_W-1:0] cursor_col;
        logic [CUR_ROW_W-1:0] cursor_row;
        logic                 scrolled;
    } console_rsp_t;

    typedef struct packed {
        console_req_t word;
        logic         typed;
        console_rsp_t rsp;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tcc_req_if req_ch ();
    tcc_rsp_if rsp_ch ();

    text_console_cursor_scroll dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Shadow state of the console.
    logic [CELL_W-1:0]  shadow_cells [CELLS];
    int unsigned        shadow_top;
    int unsigned        shadow_col;
    int unsigned        shadow_row;
    logic [COLOR_W-1:0] shadow_fg;
    logic [COLOR_W-1:0] shadow_bg;

    console_rsp_t responses_due [$];
    int           mismatches = 0;
    bit           gaps_enabled = 1'b1;

    // Rows with a typed response follow from the reset screen and the rows
    // before them; the rest are predicted.
    directed_row_t directed_rows [DIRECTED_N] = '{
        // Reset screen, both corners.
        {FUNC_READ,  8'h00, 5'd0,  7'd0,   1'b1, RESET_CELL, 7'd0, 5'd0, 1'b0},
        {FUNC_READ,  8'hFF, 5'd24, 7'd79,  1'b1, RESET_CELL, 7'd0, 5'd0, 1'b0},
        // Reads outside the screen return zero.
        {FUNC_READ,  8'h00, 5'd25, 7'd0,   1'b1, 16'h0000,   7'd0, 5'd0, 1'b0},
        {FUNC_READ,  8'hFF, 5'd31, 7'd127, 1'b1, 16'h0000,   7'd0, 5'd0, 1'b0},
        {FUNC_READ,  8'h00, 5'd0,  7'd80,  1'b1, 16'h0000,   7'd0, 5'd0, 1'b0},
        {FUNC_READ,  8'h00, 5'd24, 7'd127, 1'b1, 16'h0000,   7'd0, 5'd0, 1'b0},
        // Writes advance the cursor; read fields of a write are ignored.
        {FUNC_WRITE, 8'h41, 5'd0,  7'd0,   1'b1, 16'h0000,   7'd1, 5'd0, 1'b0},
        {FUNC_READ,  8'h00, 5'd0,  7'd0,   1'b1, 16'h0741,   7'd1, 5'd0, 1'b0},
        {FUNC_WRITE, 8'h00, 5'd31, 7'd127, 1'b1, 16'h0000,   7'd2, 5'd0, 1'b0},
        {FUNC_WRITE, 8'hFF, 5'd0,  7'd0,   1'b1, 16'h0000,   7'd3, 5'd0, 1'b0},
        // Newlines move down without touching any cell.
        {FUNC_WRITE, NEWLINE_CODE, 5'd0, 7'd0, 1'b1, 16'h0000, 7'd0, 5'd1, 1'b0},
        {FUNC_WRITE, NEWLINE_CODE, 5'd0, 7'd0, 1'b1, 16'h0000, 7'd0, 5'd2, 1'b0},
        {FUNC_READ,  8'h00, 5'd0,  7'd1,   1'b1, 16'h0700,   7'd0, 5'd2, 1'b0},
        {FUNC_READ,  8'h00, 5'd0,  7'd2,   1'b1, 16'h07FF,   7'd0, 5'd2, 1'b0},
        {FUNC_READ,  8'h00, 5'd1,  7'd0,   1'b1, RESET_CELL, 7'd0, 5'd2, 1'b0},
        {FUNC_WRITE, SPACE_CODE, 5'd0, 7'd0, 1'b1, 16'h0000, 7'd1, 5'd2, 1'b0},
        {FUNC_WRITE, 8'h7E, 5'd17, 7'd42,  1'b0, 16'h0000,   7'd0, 5'd0, 1'b0},
        {FUNC_READ,  8'h5A, 5'd2,  7'd1,   1'b0, 16'h0000,   7'd0, 5'd0, 1'b0}
    };

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned cell_addr(input int unsigned row, input int unsigned col);
        return ((row + shadow_top) % ROWS) * COLS + col;
    endfunction

    // Moves the cursor to the next line; returns 1 when the screen scrolls.
    function automatic logic advance_line();
        int unsigned c;
        shadow_col = 0;
        if (shadow_row >= ROWS - 1)
        begin
            shadow_row = ROWS - 1;
            shadow_top = (shadow_top + 1) % ROWS;
            for (c = 0; c < COLS; c++)
                shadow_cells[cell_addr(ROWS - 1, c)] = {shadow_bg, shadow_fg, SPACE_CODE};
            return 1'b1;
        end
        shadow_row++;
        return 1'b0;
    endfunction

    function automatic console_rsp_t apply_console_word(input console_req_t w);
        console_rsp_t r;
        r = '0;
        if (w.func == FUNC_READ)
        begin
            if (w.read_row < ROWS && w.read_col < COLS)
                r.cell_value = shadow_cells[cell_addr(32'(w.read_row), 32'(w.read_col))];
        end
        else if (w.char_code == NEWLINE_CODE)
        begin
            r.scrolled = advance_line();
        end
        else
        begin
            shadow_cells[cell_addr(shadow_row, shadow_col)] = {shadow_bg, shadow_fg, w.char_code};
            shadow_col++;
            if (shadow_col >= COLS)
                r.scrolled = advance_line();
        end
        r.cursor_col = CUR_COL_W'(shadow_col);
        r.cursor_row = CUR_ROW_W'(shadow_row);
        return r;
    endfunction

    // Drops valid, waits for every pending response, then lets time pass.
    task automatic drain_responses(input int extra);
        req_ch.valid <= 1'b0;
        while (responses_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic send_word(input console_req_t w, input bit typed, input console_rsp_t typed_rsp);
        console_rsp_t predicted;
        if (gaps_enabled && $urandom_range(0, 11) == 0)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                drain_responses(1);
            end
            else
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
        req_ch.valid     <= 1'b1;
        req_ch.func      <= w.func;
        req_ch.char_code <= w.char_code;
        req_ch.read_row  <= w.read_row;
        req_ch.read_col  <= w.read_col;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = apply_console_word(w);
        responses_due.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic send_write(input logic [CHAR_W-1:0] code);
        console_req_t w;
        w.func      = FUNC_WRITE;
        w.char_code = code;
        w.read_row  = RD_ROW_W'($urandom_range(0, 31));
        w.read_col  = RD_COL_W'($urandom_range(0, 127));
        send_word(w, 1'b0, '0);
    endtask

    task automatic send_read(input logic [RD_ROW_W-1:0] row, input logic [RD_COL_W-1:0] col);
        console_req_t w;
        w.func      = FUNC_READ;
        w.char_code = CHAR_W'($urandom_range(0, 255));
        w.read_row  = row;
        w.read_col  = col;
        send_word(w, 1'b0, '0);
    endtask

    // The caller lowers cfg_we after its last write.
    task automatic write_color(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_FG_COLOR)
            shadow_fg = val;
        else
            shadow_bg = val;
    endtask

    // Response ready with random stall bursts.
    initial
    begin
        int stall;
        stall = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                rsp_ch.ready <= 1'b0;
            end
            else if (gaps_enabled && $urandom_range(0, 13) == 0)
            begin
                stall = $urandom_range(0, 15);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Response checker.
    initial
    begin
        console_rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (responses_due.size() == 0)
                begin
                    $error("unexpected response word: cell_value %h cursor %0d,%0d",
                           rsp_ch.cell_value, rsp_ch.cursor_row, rsp_ch.cursor_col);
                    mismatches++;
                end
                else
                begin
                    want = responses_due.pop_front();
                    if (rsp_ch.cell_value !== want.cell_value)
                    begin
                        $error("cell_value: expected %h, got %h", want.cell_value,
                               rsp_ch.cell_value);
                        mismatches++;
                    end
                    if (rsp_ch.cursor_col !== want.cursor_col)
                    begin
                        $error("cursor_col: expected %0d, got %0d", want.cursor_col,
                               rsp_ch.cursor_col);
                        mismatches++;
                    end
                    if (rsp_ch.cursor_row !== want.cursor_row)
                    begin
                        $error("cursor_row: expected %0d, got %0d", want.cursor_row,
                               rsp_ch.cursor_row);
                        mismatches++;
                    end
                    if (rsp_ch.scrolled !== want.scrolled)
                    begin
                        $error("scrolled: expected %0d, got %0d", want.scrolled,
                               rsp_ch.scrolled);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Stimulus.
    initial
    begin
        int i;
        int phase;
        int n;
        int len;
        int k;
        int pick;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_FG_COLOR;
        cfg_data         <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.func      <= FUNC_WRITE;
        req_ch.char_code <= '0;
        req_ch.read_row  <= '0;
        req_ch.read_col  <= '0;
        shadow_top = 0;
        shadow_col = 0;
        shadow_row = 0;
        shadow_fg  = FG_RESET;
        shadow_bg  = BG_RESET;
        for (i = 0; i < CELLS; i++)
            shadow_cells[i] = RESET_CELL;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_N; i++)
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].rsp);

        for (phase = 0; phase < 4; phase++)
        begin
            if (phase > 0)
            begin
                // Colors change only once the console is quiet.
                drain_responses(SETTLE_CYCLES);
                case (phase)
                    1:
                    begin
                        write_color(CFG_FG_COLOR, 4'd0);
                        write_color(CFG_BG_COLOR, 4'd0);
                    end
                    2:
                    begin
                        write_color(CFG_FG_COLOR, 4'd15);
                        write_color(CFG_BG_COLOR, 4'd15);
                    end
                    default:
                    begin
                        write_color(CFG_BG_COLOR, CFG_DATA_W'($urandom_range(0, 15)));
                        write_color(CFG_FG_COLOR, CFG_DATA_W'($urandom_range(0, 15)));
                    end
                endcase
                cfg_we <= 1'b0;
            end
            if (phase == 3)
                gaps_enabled = 1'b0;

            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                begin
                    send_read(RD_ROW_W'($urandom_range(0, 31)),
                              RD_COL_W'($urandom_range(0, 127)));
                    n++;
                end
                else if (pick < 16)
                begin
                    send_read(RD_ROW_W'($urandom_range(0, ROWS - 1)),
                              RD_COL_W'($urandom_range(0, COLS - 1)));
                    n++;
                end
                else if (pick < 22)
                begin
                    // Read back the cell just written, or column 0 at a line start.
                    send_read(RD_ROW_W'(shadow_row),
                              RD_COL_W'((shadow_col == 0) ? 0 : shadow_col - 1));
                    n++;
                end
                else
                begin
                    // A line of text; some are long enough to wrap.
                    if ($urandom_range(0, 5) == 0)
                        len = $urandom_range(COLS - 4, COLS + 12);
                    else
                        len = $urandom_range(0, 24);
                    for (k = 0; k < len; k++)
                        send_write(CHAR_W'($urandom_range(0, 255)));
                    n += len;
                    if ($urandom_range(0, 3) != 0)
                    begin
                        send_write(NEWLINE_CODE);
                        n++;
                    end
                end
            end
        end

        drain_responses(SETTLE_CYCLES);
        if (mismatches == 0)
            $display("** text_console_cursor_scroll: PASSED **");
        else
            $display("** text_console_cursor_scroll: FAILED **");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("** text_console_cursor_scroll: FAILED **");
        $finish;
    end

endmodule
